/* sv/tbst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbst_pkg: shared types and constants of the two-base timer bank
// Entry layout, operation and status codes, widths.
// ----------------------------------------------------------------------------
package tbst_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int ADDR_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int IDX_W       = 4;
  localparam int IDX_EXT_W   = 9;
  localparam int BASE_W      = 14;
  localparam int TMO_IN_W    = 16;
  localparam int TMO_W       = 13;
  localparam int SLOW_STEP_W = 7;
  localparam int ENTRY_W     = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_CLEAR = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_IDLE    = 2'd0,
    STATUS_RUNNING = 2'd1,
    STATUS_EXPIRED = 2'd2
  } status_e;

  typedef struct packed {
    logic              slow;
    logic              run;
    logic [BASE_W-1:0] deadline;
  } entry_t;

endpackage

/* sv/tbst_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbst_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle, read data valid in the cycle after the address.
// ----------------------------------------------------------------------------
module tbst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/two_base_software_timer_bank_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_base_software_timer_bank_core: bank of one-shot timers on two time bases
//
// Request channel: in_valid_i / in_stall_o with op_i, timer_index_i,
// use_slow_base_i and timeout_i. Tick advances the fast base (and the slow
// base every 128 fast ticks); start, clear and check address one entry.
// Result channel: out_valid_o / out_stall_i with status_o, one result per
// check request only.
// For each request the entry is read from the timer RAM at acceptance, and
// modified and written back in the following cycle, during which no new
// request is taken. A check result is loaded into the output register at the
// end of that write-back cycle, and out_valid_o rises with it.
// No new request is taken before the last one is written back, as set by the
// registered RAM read and the read-modify-write of a single entry.
// Reset clears both bases and the per-entry valid bits, so every entry reads
// as zero immediately; no clearing pass is needed.
// While a result waits under out_stall_i, in_stall_o stays high and no
// request is taken until the output register drains.
// ----------------------------------------------------------------------------
module two_base_software_timer_bank_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [tbst_pkg::IDX_W-1:0]    timer_index_i,
  input  logic                          use_slow_base_i,
  input  logic [tbst_pkg::TMO_IN_W-1:0] timeout_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o
);
  import tbst_pkg::*;

  logic                   accept;
  logic [IDX_EXT_W-1:0]   idx_ext;
  logic [ADDR_W-1:0]      addr_in;
  logic                   inr_in;
  logic [TMO_W-1:0]       tmo_in;

  // stage after acceptance
  logic                   busy_q;
  op_e                    op_q;
  logic [ADDR_W-1:0]      addr_q;
  logic                   inr_q;
  logic                   slow_q;
  logic [TMO_W-1:0]       tmo_q;

  logic [BASE_W-1:0]      fast_q, fast_d, slow_base_q, slow_base_d;
  logic [TIMER_COUNT-1:0] vld_q, vld_d;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;

  logic [ENTRY_W-1:0]     rdata;
  entry_t                 ent;
  entry_t                 wentry;
  logic                   we;
  logic [BASE_W-1:0]      ref_base, start_base, diff;

  assign in_stall_o = busy_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  assign idx_ext = {{(IDX_EXT_W-IDX_W){1'b0}}, timer_index_i};
  assign addr_in = idx_ext[ADDR_W-1:0];
  assign inr_in  = (idx_ext < IDX_EXT_W'(TIMER_COUNT));
  // timeouts with bit 13 or 14 set count as zero
  assign tmo_in  = (timeout_i[14:13] != 2'b00) ? '0 : timeout_i[TMO_W-1:0];

  tbst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wentry),
    .raddr_i (addr_in),
    .rdata_o (rdata)
  );

  // never-written or cleared entries read as zero
  assign ent = (inr_q && vld_q[addr_q]) ? entry_t'(rdata) : entry_t'('0);

  assign ref_base   = ent.slow ? slow_base_q : fast_q;
  assign start_base = slow_q ? slow_base_q : fast_q;
  assign diff       = ref_base - ent.deadline;

  always_comb begin
    fast_d      = fast_q;
    slow_base_d = slow_base_q;
    vld_d       = vld_q;
    we          = 1'b0;
    wentry.slow     = slow_q;
    wentry.run      = 1'b1;
    wentry.deadline = start_base + {{(BASE_W-TMO_W){1'b0}}, tmo_q};
    out_valid_d = out_valid_q & out_stall_i;
    status_d    = status_q;
    if (busy_q) begin
      case (op_q)
        OP_TICK: begin
          fast_d = fast_q + 1'b1;
          if (fast_d[SLOW_STEP_W-1:0] == '0) begin
            slow_base_d = slow_base_q + 1'b1;
          end
        end
        OP_START: begin
          if (inr_q) begin
            we            = 1'b1;
            vld_d[addr_q] = 1'b1;
          end
        end
        OP_CLEAR: begin
          if (inr_q) begin
            vld_d[addr_q] = 1'b0;
          end
        end
        OP_CHECK: begin
          out_valid_d = 1'b1;
          if (!ent.run) begin
            status_d = STATUS_IDLE;
          end else if (diff[BASE_W-1]) begin
            status_d = STATUS_RUNNING;
          end else begin
            status_d      = STATUS_EXPIRED;
            vld_d[addr_q] = 1'b0;
          end
        end
        default: begin
          out_valid_d = out_valid_q & out_stall_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fast_q      <= '0;
      slow_base_q <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= accept;
      fast_q      <= fast_d;
      slow_base_q <= slow_base_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      addr_q <= addr_in;
      inr_q  <= inr_in;
      slow_q <= use_slow_base_i;
      tmo_q  <= tmo_in;
    end
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the two-base one-shot timer bank
// Drives directed requests, then tick, start, clear and check requests in random bursts. A scoreboard
// tracks both time bases and every timer entry, and predicts the status of
// each check. It compares the predicted status with each status the block
// returns while the result side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import tbst_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  class timer_status_scoreboard;
    logic [BASE_W-1:0] fast_base;
    logic [BASE_W-1:0] slow_base;
    entry_t            entries[TIMER_COUNT];
    status_e           expected_status[$];
    int                errors;

    function new();
      fast_base = '0;
      slow_base = '0;
      foreach (entries[i]) entries[i] = '0;
      errors = 0;
    endfunction

    // Updates the timer state for one accepted request; a check queues its status.
    function void apply_request(op_e op, logic [IDX_W-1:0] idx, logic slow,
                                logic [TMO_IN_W-1:0] tmo);
      logic [TMO_IN_W-1:0] t;
      logic [BASE_W-1:0]   base;
      logic [BASE_W-1:0]   diff;
      entry_t              e;
      status_e             st;
      case (op)
        OP_TICK: begin
          fast_base = fast_base + 1'b1;
          if (fast_base[SLOW_STEP_W-1:0] == '0) slow_base = slow_base + 1'b1;
        end
        OP_START: begin
          if (idx < TIMER_COUNT) begin
            t = tmo;
            if (t[14:13] != 2'b00) t = '0;  // out-of-range timeout means zero
            base = slow ? slow_base : fast_base;
            e.slow = slow;
            e.run = 1'b1;
            e.deadline = base + {1'b0, t[TMO_W-1:0]};
            entries[idx] = e;
          end
        end
        OP_CLEAR: begin
          if (idx < TIMER_COUNT) entries[idx] = '0;
        end
        default: begin
          st = STATUS_IDLE;
          if (idx < TIMER_COUNT) begin
            e = entries[idx];
            if (e.run) begin
              base = e.slow ? slow_base : fast_base;
              diff = base - e.deadline;
              if (diff[BASE_W-1]) begin
                st = STATUS_RUNNING;
              end else begin
                st = STATUS_EXPIRED;
                entries[idx] = '0;
              end
            end
          end
          expected_status.push_back(st);
        end
      endcase
    endfunction

    function void compare_status(logic [1:0] got);
      status_e exp;
      if (expected_status.size() == 0) begin
        $error("status: no check pending, actual %0d", got);
        errors++;
      end else begin
        exp = expected_status.pop_front();
        if (got !== exp) begin
          $error("status mismatch: expected %0d, actual %0d", exp, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          op_i = OP_TICK;
  logic [IDX_W-1:0]    timer_index_i = '0;
  logic                use_slow_base_i = 1'b0;
  logic [TMO_IN_W-1:0] timeout_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          status_o;

  timer_status_scoreboard sb;
  int                     burst_left = 1;
  int                     idle_cycles = 0;
  stall_mode_e            stall_mode = STALL_NONE;
  int                     stall_phase = 0;

  two_base_software_timer_bank_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .timer_index_i   (timer_index_i),
    .use_slow_base_i (use_slow_base_i),
    .timeout_i       (timeout_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Presents one request, waits for acceptance, then may open a gap.
  task automatic send_request(op_e op, logic [IDX_W-1:0] idx, logic slow,
                              logic [TMO_IN_W-1:0] tmo);
    int gap;
    in_valid_i <= 1'b1;
    op_i <= op;
    timer_index_i <= idx;
    use_slow_base_i <= slow;
    timeout_i <= tmo;
    do @(posedge clk_i); while (in_stall_o);
    sb.apply_request(op, idx, slow, tmo);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic tick_n(int n);
    repeat (n) send_request(OP_TICK, '0, 1'b0, '0);
  endtask

  // Result side: the stall pattern is redrawn whenever its phase counter runs out.
  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_phase <= $urandom_range(16, 96);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= (stall_phase % 16 < 9);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.compare_status(status_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int               r;
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             slow;
    logic [TMO_IN_W-1:0] tmo;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, zero and maximum timeouts, forced-zero timeouts
    send_request(OP_CHECK, 4'd0, 1'b0, '0);
    send_request(OP_CHECK, 4'd15, 1'b0, '0);
    send_request(OP_START, 4'd0, 1'b0, 16'h0000);
    send_request(OP_CHECK, 4'd0, 1'b0, '0);
    send_request(OP_CHECK, 4'd0, 1'b0, '0);
    send_request(OP_START, 4'd1, 1'b0, 16'h1FFF);
    send_request(OP_CHECK, 4'd1, 1'b0, '0);
    send_request(OP_START, 4'd2, 1'b1, 16'h2000);
    send_request(OP_CHECK, 4'd2, 1'b0, '0);
    send_request(OP_START, 4'd3, 1'b0, 16'h4000);
    send_request(OP_CHECK, 4'd3, 1'b0, '0);
    // bit 15 of the timeout is ignored: deadline is base + 5
    send_request(OP_START, 4'd4, 1'b0, 16'h8005);
    send_request(OP_CHECK, 4'd4, 1'b0, '0);
    tick_n(5);
    send_request(OP_CHECK, 4'd4, 1'b0, '0);
    send_request(OP_CLEAR, 4'd1, 1'b0, '0);
    send_request(OP_CHECK, 4'd1, 1'b0, '0);
    // restart overwrites a running entry
    send_request(OP_START, 4'd5, 1'b0, 16'd100);
    send_request(OP_START, 4'd5, 1'b0, 16'hFFFF);
    send_request(OP_CHECK, 4'd5, 1'b0, '0);
    send_request(OP_START, 4'd15, 1'b1, 16'h1FFF);
    send_request(OP_CHECK, 4'd15, 1'b1, '0);

    for (int n = 0; n < 550; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_TICK;
      else if (r < 62) op = OP_START;
      else if (r < 70) op = OP_CLEAR;
      else op = OP_CHECK;
      // favor a few entries so that starts and checks meet
      idx = IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
      slow = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       tmo = TMO_IN_W'($urandom_range(0, 16'hFFFF));
        1:       tmo = TMO_IN_W'($urandom_range(0, 16'h1FFF));
        default: tmo = TMO_IN_W'(slow ? $urandom_range(0, 2) : $urandom_range(0, 40));
      endcase
      if ($urandom_range(0, 7) == 0) tmo[15] = 1'b1;
      send_request(op, idx, slow, tmo);
    end

    in_valid_i <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_status.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
